>>> design/alcm_pkg.sv
// ----------------------------------------------------------------------------
// alcm_pkg - shared definitions of the access latency cache model
// Field widths, register indexes, access codes and the small helper
// functions used by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package alcm_pkg;

   localparam int TAG_W      = 49;
   localparam int LINE_W     = 48;
   localparam int ADDR_W     = 48;
   localparam int BYTES_W    = 13;
   localparam int KIND_W     = 3;
   localparam int CNT_W      = 9;
   localparam int DELAY_W    = 25;
   localparam int LAT_W      = 16;
   localparam int THR_W      = 54;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam int MAX_BYTES = 4096;
   localparam int DEF_SETS  = 64;
   localparam int DEF_WAYS  = 8;

   localparam logic [63:0] RNG_RESET    = 64'h6a09e667f3bcc909;
   localparam logic [63:0] RNG_ZERO_FIX = 64'h9e3779b97f4a7c15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CACHE_MODE = 3'd0,
      CSR_HIT_DISC   = 3'd1,
      CSR_LINE_LOG2  = 3'd2,
      CSR_HIT_THRESH = 3'd3,
      CSR_HIT_DELAY  = 3'd4,
      CSR_SW_DELAYS  = 3'd5,
      CSR_HW_DELAYS  = 3'd6
   } csr_index_type;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_RATE = 2'd1;

   localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ALOAD  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ASTORE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ARMW   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLUSH  = 3'd4;

   // One xorshift64 step; a zero state is replaced first.
   function automatic logic [63:0] rng_next(input logic [63:0] s);
      logic [63:0] x;
      x = (s == 64'd0) ? RNG_ZERO_FIX : s;
      x = x ^ (x << 13);
      x = x ^ (x >> 7);
      x = x ^ (x << 17);
      return x;
   endfunction

   // Per-line miss latency for a pool and access kind.
   function automatic logic [LAT_W-1:0] miss_latency(
      input logic              pool,
      input logic [KIND_W-1:0] kind,
      input logic [47:0]       sw,
      input logic [59:0]       hw
   );
      logic [LAT_W-1:0] lat;
      lat = '0;
      if (!pool) begin
         case (kind)
            KIND_READ, KIND_ALOAD: lat = sw[15:0];
            KIND_FLUSH:            lat = sw[31:16];
            default:               lat = sw[47:32];
         endcase
      end else begin
         case (kind)
            KIND_READ:   lat = {4'b0, hw[11:0]};
            KIND_ALOAD:  lat = {4'b0, hw[23:12]};
            KIND_ASTORE: lat = {4'b0, hw[35:24]};
            KIND_ARMW:   lat = {4'b0, hw[47:36]};
            default:     lat = {4'b0, hw[59:48]};
         endcase
      end
      return lat;
   endfunction

endpackage

>>> design/alcm_if.sv
// ----------------------------------------------------------------------------
// alcm_if - channel interfaces of the access latency cache model
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface alcm_req_if import alcm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                pool;
   logic [KIND_W-1:0]   access_kind;
   logic [ADDR_W-1:0]   address;
   logic [BYTES_W-1:0]  byte_count;

   modport source (output valid, pool, access_kind, address, byte_count, input ready);
   modport sink   (input valid, pool, access_kind, address, byte_count, output ready);
endinterface

interface alcm_rsp_if import alcm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CNT_W-1:0]   line_count;
   logic [CNT_W-1:0]   hit_count;
   logic [CNT_W-1:0]   miss_count;
   logic [DELAY_W-1:0] delay_ns;

   modport source (output valid, line_count, hit_count, miss_count, delay_ns, input ready);
   modport sink   (input valid, line_count, hit_count, miss_count, delay_ns, output ready);
endinterface

interface alcm_csr_if import alcm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, reg_index, data, input ready);
   modport sink   (input valid, reg_index, data, output ready);
endinterface

>>> design/access_latency_cache_model_core.sv
// ----------------------------------------------------------------------------
// access_latency_cache_model_core - cache hit/miss latency model
// Splits one memory access into cache lines, judges each line a hit or a
// miss and returns line, hit and miss counts with the summed delay.
// ----------------------------------------------------------------------------
// Timing: after reset the tag memory is swept clear, one set a cycle; no
// item is taken meanwhile (register writes are). An item then passes through
// accept, setup and finish when its byte count is zero or the cache is off,
// adds one generator step per line in fixed hit rate mode, and in LRU mode
// first finds the set index of the first line: taken straight from the tag
// when SETS is a power of two, else reduced from the tag one byte a cycle
// over all seven tag bytes. Each LRU line reads its whole set row from the
// single-port tag memory, then compares all ways at once and writes the
// reordered row back. Results leave through an output register, so the
// next item is accepted while a result still waits.
// ----------------------------------------------------------------------------
module access_latency_cache_model_core import alcm_pkg::*; #(
   parameter int SETS = DEF_SETS,
   parameter int WAYS = DEF_WAYS
) (
   input  logic        clock,
   input  logic        reset,
   alcm_req_if.sink    req_bus,
   alcm_rsp_if.source  rsp_bus,
   alcm_csr_if.sink    csr_bus
);

   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int POS_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam bit SET_POW2 = ((SETS & (SETS - 1)) == 0);

   // byte-wise remainder of the first tag: digit count, partial remainder
   // width and the scaled reciprocal of SETS that yields each quotient digit
   localparam int DIG_N  = (TAG_W + 7) / 8;
   localparam int DIG_IW = (DIG_N > 1) ? $clog2(DIG_N) : 1;
   localparam int MOD_W  = SET_W + 8;
   localparam int RCP_SH = MOD_W + SET_W;
   localparam int RCP_W  = MOD_W + 2;
   localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((64'd1 << RCP_SH) + 64'(SETS) - 64'd1) / 64'(SETS));

   // one way: valid bit on top of the tag
   typedef logic [WAYS-1:0][TAG_W:0] row_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SETUP, ST_SETIDX, ST_RNG, ST_READ, ST_CMP, ST_FIN
   } state_type;

   state_type state_ff, state_in;

   // captured item
   logic               pool_ff, pool_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;

   // line walk
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SET_W-1:0]   set_ff, set_in;
   logic [SET_W-1:0]   mod_ff, mod_in;
   logic [DIG_IW-1:0]  bit_ff, bit_in;
   logic [SET_W-1:0]   clr_ff, clr_in;
   logic [LAT_W-1:0]   miss_d_ff, miss_d_in;
   logic [CNT_W-1:0]   raw_ff, raw_in;
   logic [CNT_W-1:0]   hit_ff, hit_in;
   logic [CNT_W-1:0]   miss_ff, miss_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [63:0]        rng_ff, rng_in;

   // registers
   logic [1:0]         mode_ff, mode_in;
   logic               hd_en_ff, hd_en_in;
   logic [3:0]         lsl_ff, lsl_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [LAT_W-1:0]   hit_d_ff, hit_d_in;
   logic [47:0]        sw_ff, sw_in;
   logic [59:0]        hw_ff, hw_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   rsp_line_ff, rsp_line_in;
   logic [CNT_W-1:0]   rsp_hit_ff, rsp_hit_in;
   logic [CNT_W-1:0]   rsp_miss_ff, rsp_miss_in;
   logic [DELAY_W-1:0] rsp_delay_ff, rsp_delay_in;

   // tag memory: one row per set
   row_type            mem [SETS];
   row_type            row_rd_ff;
   logic               mem_we;
   logic [SET_W-1:0]   mem_wa;
   row_type            mem_wd;

   // datapath
   logic [TAG_W-1:0]   tag_w;
   logic [3:0]         sh;
   logic [BYTES_W-1:0] bytes_sat;
   logic [ADDR_W:0]    end_addr;
   logic [LINE_W-1:0]  first_line;
   logic [ADDR_W:0]    last_line;
   logic [CNT_W-1:0]   raw_cnt;
   logic [63:0]        rng_new;
   logic               rate_hit;
   logic [WAYS-1:0]    way_hit;
   logic [WAYS-1:0]    way_free;
   logic [POS_W-1:0]   pos;
   logic               lru_hit;
   row_type            new_row;
   logic               counted;
   logic [SET_W+1:0]   set_sum;
   logic [DIG_N*8-1:0] tag_pad;
   logic [7:0]         mod_dig;
   logic [MOD_W-1:0]   mod_sum;
   logic [MOD_W+RCP_W-1:0] mod_prod;
   logic [7:0]         mod_quo;
   logic [SET_W-1:0]   mod_next;
   logic               req_take;
   logic               out_free;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.line_count = rsp_line_ff;
   assign rsp_bus.hit_count  = rsp_hit_ff;
   assign rsp_bus.miss_count = rsp_miss_ff;
   assign rsp_bus.delay_ns   = rsp_delay_ff;

   // Range to lines: clamp the line size, saturate the count, no wrap.
   always_comb begin
      sh = lsl_ff;
      if (lsl_ff < 4'd4) begin
         sh = 4'd4;
      end else if (lsl_ff > 4'd12) begin
         sh = 4'd12;
      end
      bytes_sat  = (32'(bytes_ff) > MAX_BYTES) ? BYTES_W'(MAX_BYTES) : bytes_ff;
      end_addr   = {1'b0, addr_ff} + (ADDR_W+1)'(bytes_sat) - (ADDR_W+1)'(1);
      first_line = addr_ff >> sh;
      last_line  = end_addr >> sh;
      raw_cnt    = CNT_W'(last_line - {1'b0, first_line} + (ADDR_W+1)'(1));
   end

   assign tag_w    = {line_ff, pool_ff};
   assign rng_new  = rng_next(rng_ff);
   assign rate_hit = {1'b0, rng_new[63:11]} < thr_ff;

   // All ways compared at once; valid ways are packed from way 0, so the
   // lowest hit-or-free way is the move-to-front position.
   always_comb begin
      pos = POS_W'(WAYS - 1);
      for (int i = 0; i < WAYS; i++) begin
         way_hit[i]  = row_rd_ff[i][TAG_W] && (row_rd_ff[i][TAG_W-1:0] == tag_w);
         way_free[i] = !row_rd_ff[i][TAG_W];
      end
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (way_hit[i] || way_free[i]) begin
            pos = POS_W'(i);
         end
      end
      lru_hit = |way_hit;
      new_row = row_rd_ff;
      new_row[0] = {1'b1, tag_w};
      for (int j = 1; j < WAYS; j++) begin
         if (POS_W'(j) <= pos) begin
            new_row[j] = row_rd_ff[j-1];
         end
      end
   end

   assign counted = ((mode_ff == MODE_RATE) ? rate_hit : lru_hit) && hd_en_ff;

   // Next line's set: tag advances by two, fold back below SETS.
   always_comb begin
      set_sum = {2'b0, set_ff} + (SET_W+2)'(2);
      if (set_sum >= (SET_W+2)'(SETS)) begin
         set_sum = set_sum - (SET_W+2)'(SETS);
      end
      if (set_sum >= (SET_W+2)'(SETS)) begin
         set_sum = set_sum - (SET_W+2)'(SETS);
      end
   end

   // Fold one byte of the first tag into its remainder modulo SETS; the
   // quotient digit comes from a multiply by the scaled reciprocal.
   always_comb begin
      tag_pad  = (DIG_N*8)'(tag_w);
      mod_dig  = tag_pad[bit_ff*8 +: 8];
      mod_sum  = {mod_ff, mod_dig};
      mod_prod = (MOD_W+RCP_W)'(mod_sum) * (MOD_W+RCP_W)'(RCP);
      mod_quo  = 8'(mod_prod >> RCP_SH);
      mod_next = SET_W'(mod_sum - MOD_W'(mod_quo) * MOD_W'(SETS));
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = set_ff;
      mem_wd = new_row;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = '0;
      end else if (state_ff == ST_CMP) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      row_rd_ff <= mem[set_ff];
   end

   always_comb begin
      state_in     = state_ff;
      pool_in      = pool_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      bytes_in     = bytes_ff;
      line_in      = line_ff;
      cnt_in       = cnt_ff;
      set_in       = set_ff;
      mod_in       = mod_ff;
      bit_in       = bit_ff;
      clr_in       = clr_ff;
      miss_d_in    = miss_d_ff;
      raw_in       = raw_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      delay_in     = delay_ff;
      rng_in       = rng_ff;
      mode_in      = mode_ff;
      hd_en_in     = hd_en_ff;
      lsl_in       = lsl_ff;
      thr_in       = thr_ff;
      hit_d_in     = hit_d_ff;
      sw_in        = sw_ff;
      hw_in        = hw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_line_in  = rsp_line_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_miss_in  = rsp_miss_ff;
      rsp_delay_in = rsp_delay_ff;

      // register writes; the user must issue them only while idle, the block itself does not enforce it
      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_CACHE_MODE: mode_in  = csr_bus.data[1:0];
            CSR_HIT_DISC:   hd_en_in = csr_bus.data[0];
            CSR_LINE_LOG2:  lsl_in   = csr_bus.data[3:0];
            CSR_HIT_THRESH: thr_in   = csr_bus.data[THR_W-1:0];
            CSR_HIT_DELAY:  hit_d_in = csr_bus.data[LAT_W-1:0];
            CSR_SW_DELAYS:  sw_in    = csr_bus.data[47:0];
            CSR_HW_DELAYS:  hw_in    = csr_bus.data[59:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_W'(1);
            if (32'(clr_ff) == SETS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               pool_in  = req_bus.pool;
               kind_in  = req_bus.access_kind;
               addr_in  = req_bus.address;
               bytes_in = req_bus.byte_count;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            miss_d_in = miss_latency(pool_ff, kind_ff, sw_ff, hw_ff);
            line_in   = first_line;
            cnt_in    = raw_cnt;
            raw_in    = raw_cnt;
            hit_in    = '0;
            miss_in   = '0;
            delay_in  = '0;
            mod_in    = '0;
            bit_in    = DIG_IW'(DIG_N - 1);
            if (bytes_ff == '0) begin
               raw_in   = '0;
               state_in = ST_FIN;
            end else if (mode_ff == MODE_NONE) begin
               miss_in  = raw_cnt;
               delay_in = DELAY_W'(raw_cnt) *
                          DELAY_W'(miss_latency(pool_ff, kind_ff, sw_ff, hw_ff));
               state_in = ST_FIN;
            end else if (mode_ff == MODE_RATE) begin
               state_in = ST_RNG;
            end else begin
               state_in = ST_SETIDX;
            end
         end
         ST_SETIDX: begin
            if (SET_POW2) begin
               set_in   = SET_W'(tag_w) & SET_W'(SETS - 1);
               state_in = ST_READ;
            end else begin
               mod_in = mod_next;
               bit_in = bit_ff - DIG_IW'(1);
               if (bit_ff == '0) begin
                  set_in   = mod_next;
                  state_in = ST_READ;
               end
            end
         end
         ST_RNG: begin
            // one draw per line
            rng_in   = rng_new;
            hit_in   = hit_ff + CNT_W'(counted);
            miss_in  = miss_ff + CNT_W'(!counted);
            delay_in = delay_ff + (counted ? DELAY_W'(hit_d_ff) : DELAY_W'(miss_d_ff));
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // row write-back happens on this edge
            hit_in   = hit_ff + CNT_W'(counted);
            miss_in  = miss_ff + CNT_W'(!counted);
            delay_in = delay_ff + (counted ? DELAY_W'(hit_d_ff) : DELAY_W'(miss_d_ff));
            cnt_in   = cnt_ff - CNT_W'(1);
            line_in  = line_ff + LINE_W'(1);
            set_in   = SET_W'(set_sum);
            state_in = (cnt_ff == CNT_W'(1)) ? ST_FIN : ST_READ;
         end
         ST_FIN: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_line_in  = raw_ff;
               rsp_hit_in   = hit_ff;
               rsp_miss_in  = miss_ff;
               rsp_delay_in = delay_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rng_ff       <= RNG_RESET;
         mode_ff      <= MODE_NONE;
         hd_en_ff     <= 1'b1;
         lsl_ff       <= 4'd6;
         thr_ff       <= '0;
         hit_d_ff     <= '0;
         sw_ff        <= '0;
         hw_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         rng_ff       <= rng_in;
         mode_ff      <= mode_in;
         hd_en_ff     <= hd_en_in;
         lsl_ff       <= lsl_in;
         thr_ff       <= thr_in;
         hit_d_ff     <= hit_d_in;
         sw_ff        <= sw_in;
         hw_ff        <= hw_in;
      end
      pool_ff      <= pool_in;
      kind_ff      <= kind_in;
      addr_ff      <= addr_in;
      bytes_ff     <= bytes_in;
      line_ff      <= line_in;
      cnt_ff       <= cnt_in;
      set_ff       <= set_in;
      mod_ff       <= mod_in;
      bit_ff       <= bit_in;
      miss_d_ff    <= miss_d_in;
      raw_ff       <= raw_in;
      hit_ff       <= hit_in;
      miss_ff      <= miss_in;
      delay_ff     <= delay_in;
      rsp_line_ff  <= rsp_line_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_miss_ff  <= rsp_miss_in;
      rsp_delay_ff <= rsp_delay_in;
   end

   // accepted item always enters setup
   a_take_setup: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_SETUP)
      else $error("accepted item did not enter setup");

   // every walked line counted exactly once
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |-> (10'(hit_ff) + 10'(miss_ff)) == 10'(raw_ff))
      else $error("hit and miss counts do not add up to line count");

   // a finished result lands in the output register
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free) |=> rsp_valid_ff)
      else $error("finished result not presented");

   // no item is taken and the memory is written throughout the clearing sweep
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> (!req_take && mem_we))
      else $error("item taken or memory idle during clear");

endmodule
